/* hdl/atcl_pkg.sv */
`default_nettype none

package atcl_pkg;

	localparam int KIND_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 9;
	localparam int STATUS_W = 3;
	localparam int LENGTH_W = 9;

	localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ_ALT = 2'd3;

	localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ERASED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BLANK    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_READ     = 3'd6;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd7;

	localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
	localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_DEL       = 8'h7F;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  rx_byte;
		logic [INDEX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LENGTH_W-1:0] command_length;
		logic [BYTE_W-1:0]   read_data;
		logic                in_quotes;
	} result_t;

endpackage

`default_nettype wire

/* hdl/atcl_stream_if.sv */
`default_nettype none

interface atcl_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/atcl_ram.sv */
`default_nettype none

module atcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/at_command_line_assembler.sv */
// Command line assembler for a serial command port.
// Channel request (sink, atcl_pkg::item_t): kind 0 feeds one received byte,
// kind 1 (and 3) reads a byte of the held command, kind 2 releases it.
// Channel response (source, atcl_pkg::result_t): exactly one beat for every
// request beat, in order, with status, length, read data and quote flag.
// An accepted request's response is registered and shows in the next cycle.
// Throughput is one request per cycle unless the receiver stalls; the line
// store is one RAM with a single write port and a registered read port,
// and the first printable-or-empty byte is tracked per byte, so a line end
// needs no scan. A held command blocks further bytes (busy status) until a
// release. When the receiver stalls, the response register holds its beat
// and request.ready follows response.ready, so a new beat still enters in the
// cycle the old one leaves. Reset clears fill, quote, busy, held length and
// the decisive-byte tracking at once; the line store is not cleared and no
// pass over it is needed. LINE_DEPTH sets the store size; the longest line
// is LINE_DEPTH-1 bytes.
`default_nettype none

module at_command_line_assembler #(
	parameter int LINE_DEPTH = 512
) (
	input wire logic    clk,
	input wire logic    arst_n,
	atcl_stream_if.sink   request,
	atcl_stream_if.source response
);

	import atcl_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = (AW > INDEX_W) ? AW : INDEX_W;
	localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

	item_t item;

	logic          accept;
	logic [AW-1:0] fill_q, fill_d;
	logic          quote_q, quote_d;
	logic          busy_q, busy_d;
	logic [AW-1:0] held_q, held_d;
	logic          dseen_q, dseen_d;
	logic          dprint_q, dprint_d;
	logic [AW-1:0] dpos_q, dpos_d;

	logic [STATUS_W-1:0] status_d, status_s1;
	logic [AW-1:0]       length_d, length_s1;
	logic                rd_hit_d, rd_hit_s1;
	logic                quote_s1;
	logic                valid_s1;

	logic          ram_we;
	logic [BYTE_W-1:0] ram_rdata;
	logic [AW-1:0] fill_dec;
	logic          decisive;

	assign item   = request.data;
	assign request.ready = !valid_s1 || response.ready;
	assign accept = request.valid && request.ready;

	assign fill_dec = (fill_q != '0) ? fill_q - AW'(1) : fill_q;
	assign decisive = (item.rx_byte == CH_NUL) ||
		(item.rx_byte >= CH_PRINT_LO && item.rx_byte <= CH_PRINT_HI);

	always_comb begin
		fill_d   = fill_q;
		quote_d  = quote_q;
		busy_d   = busy_q;
		held_d   = held_q;
		dseen_d  = dseen_q;
		dprint_d = dprint_q;
		dpos_d   = dpos_q;
		status_d = ST_READ;
		length_d = held_q;
		rd_hit_d = 1'b0;
		ram_we   = 1'b0;
		unique case (item.kind) inside
			KIND_BYTE: begin
				if (busy_q) begin
					status_d = ST_BUSY;
				end else if (item.rx_byte == CH_BACKSPACE || item.rx_byte == CH_DEL) begin
					status_d = ST_ERASED;
					fill_d   = fill_dec;
					if (dseen_q && fill_dec <= dpos_q) begin
						dseen_d = 1'b0;
					end
				end else if (!quote_q && item.rx_byte == CH_CR) begin
					fill_d   = '0;
					quote_d  = 1'b0;
					dseen_d  = 1'b0;
					dprint_d = 1'b0;
					dpos_d   = '0;
					if (dseen_q && dprint_q) begin
						busy_d   = 1'b1;
						held_d   = fill_q;
						status_d = ST_READY;
					end else begin
						status_d = ST_BLANK;
					end
				end else if (fill_q >= FILL_MAX) begin
					status_d = ST_OVERFLOW;
				end else begin
					status_d = ST_STORED;
					ram_we   = 1'b1;
					fill_d   = fill_q + AW'(1);
					if (!dseen_q && decisive) begin
						dseen_d  = 1'b1;
						dprint_d = (item.rx_byte != CH_NUL);
						dpos_d   = fill_q;
					end
					if (item.rx_byte == CH_QUOTE) begin
						quote_d = !quote_q;
					end
				end
				length_d = fill_d;
			end
			KIND_RELEASE: begin
				busy_d   = 1'b0;
				held_d   = '0;
				status_d = ST_RELEASED;
				length_d = '0;
			end
			KIND_READ, KIND_READ_ALT: begin
				status_d = ST_READ;
				length_d = held_q;
				rd_hit_d = CW'(item.read_index) < CW'(held_q);
			end
			default: begin
				status_d = ST_READ;
			end
		endcase
	end

	atcl_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (accept && ram_we),
		.waddr(fill_q),
		.wdata(item.rx_byte),
		.re   (accept),
		.raddr(AW'(item.read_index)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			quote_q  <= 1'b0;
			busy_q   <= 1'b0;
			held_q   <= '0;
			dseen_q  <= 1'b0;
			dprint_q <= 1'b0;
			dpos_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fill_q   <= fill_d;
				quote_q  <= quote_d;
				busy_q   <= busy_d;
				held_q   <= held_d;
				dseen_q  <= dseen_d;
				dprint_q <= dprint_d;
				dpos_q   <= dpos_d;
				valid_s1 <= 1'b1;
			end else if (response.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			length_s1 <= length_d;
			rd_hit_s1 <= rd_hit_d;
			quote_s1  <= quote_d;
		end
	end

	assign response.valid = valid_s1;
	assign response.data  = '{
		status:         status_s1,
		command_length: LENGTH_W'(length_s1),
		read_data:      rd_hit_s1 ? ram_rdata : '0,
		in_quotes:      quote_s1
	};

	a_busy_holds_line: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (held_q != '0))
		else $error("busy without a held command");

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (held_q == '0))
		else $error("held length left while idle");

	a_busy_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (fill_q == '0 && !quote_q))
		else $error("line assembly advanced while busy");

	a_decisive_inside: assert property (@(posedge clk) disable iff (!arst_n)
		dseen_q |-> (dpos_q < fill_q))
		else $error("decisive byte beyond fill");

endmodule

`default_nettype wire

/* test/at_command_line_assembler_test.sv */
module at_command_line_assembler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import atcl_pkg::*;

	localparam int LINE_DEPTH     = 512;
	localparam int RANDOM_ITEMS   = 1950;
	localparam int HOLDOFF_CYCLES = 200;
	localparam int QUIET_LIMIT    = 2000;
	localparam int DIR_ROWS       = 25;

	typedef struct packed {
		item_t   cmd;
		logic    typed;
		result_t want;
	} step_row_t;

	logic clk;
	logic arst_n;

	atcl_stream_if #(.T(item_t))   request_ch ();
	atcl_stream_if #(.T(result_t)) response_ch ();

	at_command_line_assembler #(
		.LINE_DEPTH(LINE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.response(response_ch)
	);

	logic [BYTE_W-1:0]   line_copy [LINE_DEPTH];
	bit                  written [LINE_DEPTH];
	logic [LENGTH_W-1:0] fill_len;
	logic [LENGTH_W-1:0] held_len;
	logic [LENGTH_W-1:0] first_pos;
	bit                  quote_open;
	bit                  busy_held;
	bit                  first_seen;
	bit                  first_printable;

	result_t pending_results [$];
	result_t oldest;
	result_t observed;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_req;
	int hold_served;
	int hold_left;
	int beats_in;
	int beats_out;
	int failures;
	int quiet_cycles;
	int status_seen [8];

	step_row_t directed_rows [DIR_ROWS] = '{
		'{'{KIND_BYTE, CH_BACKSPACE, 9'd0}, 1'b1, '{ST_ERASED, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_BYTE, CH_CR, 9'd0}, 1'b1, '{ST_BLANK, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_RELEASE, 8'd0, 9'd0}, 1'b1, '{ST_RELEASED, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_BYTE, 8'h20, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_NUL, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, 8'h41, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_CR, 9'd0}, 1'b1, '{ST_BLANK, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_BYTE, 8'h80, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, 8'hFF, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_PRINT_LO, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_DEL, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_NUL, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_DEL, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_PRINT_HI, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_QUOTE, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_CR, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_BACKSPACE, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_QUOTE, 9'd0}, 1'b0, '0},
		'{'{KIND_BYTE, CH_CR, 9'd0}, 1'b1, '{ST_READY, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_BYTE, 8'h58, 9'd0}, 1'b1, '{ST_BUSY, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_READ, 8'd0, 9'd0}, 1'b0, '0},
		'{'{KIND_READ_ALT, 8'hFF, 9'd4}, 1'b0, '0},
		'{'{KIND_READ, 8'd0, 9'd3}, 1'b0, '0},
		'{'{KIND_RELEASE, 8'd0, 9'd0}, 1'b1, '{ST_RELEASED, 9'd0, 8'd0, 1'b0}},
		'{'{KIND_READ, 8'd0, 9'd0}, 1'b1, '{ST_READ, 9'd0, 8'd0, 1'b0}}
	};

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic result_t assemble_step(input item_t it);
		result_t r;
		logic [BYTE_W-1:0] b;
		r = '0;
		b = it.rx_byte;
		case (it.kind)
		KIND_BYTE: begin
			if (busy_held) begin
				r.status = ST_BUSY;
			end else if (b == CH_BACKSPACE || b == CH_DEL) begin
				if (fill_len != 0)
					fill_len = fill_len - 1'b1;
				if (first_seen && fill_len <= first_pos)
					first_seen = 1'b0;
				r.status = ST_ERASED;
			end else if (!quote_open && b == CH_CR) begin
				if (first_seen && first_printable) begin
					busy_held = 1'b1;
					held_len = fill_len;
					r.status = ST_READY;
				end else begin
					r.status = ST_BLANK;
				end
				fill_len = '0;
				quote_open = 1'b0;
				first_seen = 1'b0;
				first_printable = 1'b0;
				first_pos = '0;
			end else if (fill_len >= LINE_DEPTH - 1) begin
				r.status = ST_OVERFLOW;
			end else begin
				line_copy[fill_len] = b;
				written[fill_len] = 1'b1;
				if (!first_seen && (b == CH_NUL || (b >= CH_PRINT_LO && b <= CH_PRINT_HI))) begin
					first_seen = 1'b1;
					first_printable = (b != CH_NUL);
					first_pos = fill_len;
				end
				fill_len = fill_len + 1'b1;
				if (b == CH_QUOTE)
					quote_open = !quote_open;
				r.status = ST_STORED;
			end
			r.command_length = fill_len;
		end
		KIND_RELEASE: begin
			busy_held = 1'b0;
			held_len = '0;
			r.status = ST_RELEASED;
			r.command_length = '0;
		end
		default: begin
			r.status = ST_READ;
			r.command_length = held_len;
			if (it.read_index < held_len)
				r.read_data = line_copy[it.read_index];
		end
		endcase
		r.in_quotes = quote_open;
		return r;
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		int idx;
		if (held_len != 0 && $urandom_range(3) != 0)
			return INDEX_W'($urandom_range(held_len - 1));
		idx = $urandom_range(LINE_DEPTH - 2);
		while (idx > 0 && !written[idx])
			idx--;
		return INDEX_W'(idx);
	endfunction

	task automatic send_item(input item_t it, input bit typed = 1'b0,
			input result_t typed_want = '0);
		result_t guess;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(negedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.data <= it;
		do @(posedge clk); while (!request_ch.ready);
		guess = assemble_step(it);
		pending_results.push_back(typed ? typed_want : guess);
		beats_in++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(item_t'{KIND_BYTE, b, pick_index()});
	endtask

	task automatic feed_line(input int len, input bit tidy);
		int roll;
		int l_erase, l_quote, l_skip, l_cr, l_nul;
		logic [BYTE_W-1:0] b;
		if (tidy) begin
			l_erase = 8; l_quote = 14; l_skip = 20; l_cr = 22; l_nul = 24;
		end else begin
			l_erase = 20; l_quote = 22; l_skip = 70; l_cr = 72; l_nul = 85;
		end
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (roll < l_erase) begin
				b = roll[0] ? CH_BACKSPACE : CH_DEL;
			end else if (roll < l_quote) begin
				b = CH_QUOTE;
			end else if (roll < l_skip) begin
				case ($urandom_range(2))
				0: b = 8'h20;
				1: b = BYTE_W'($urandom_range(8'h80, 8'hFF));
				default: b = BYTE_W'($urandom_range(8'h01, 8'h07));
				endcase
			end else if (roll < l_cr) begin
				b = CH_CR;
			end else if (roll < l_nul) begin
				b = CH_NUL;
			end else begin
				b = BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
			end
			send_byte(b);
		end
	endtask

	task automatic finish_line(input int reads);
		while (quote_open)
			send_byte(fill_len >= LINE_DEPTH - 1 ? CH_DEL : CH_QUOTE);
		send_byte(CH_CR);
		if (busy_held) begin
			repeat (reads) begin
				if ($urandom_range(7) == 0)
					send_byte(BYTE_W'($urandom_range(255)));
				else
					send_item(item_t'{($urandom_range(5) == 0) ? KIND_READ_ALT : KIND_READ,
						BYTE_W'($urandom_range(255)), pick_index()});
			end
			send_item(item_t'{KIND_RELEASE, BYTE_W'($urandom_range(255)), pick_index()});
		end
	endtask

	always @(negedge clk) begin
		if (hold_req != hold_served) begin
			hold_served <= hold_req;
			hold_left <= HOLDOFF_CYCLES;
			response_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			response_ch.ready <= 1'b0;
		end else begin
			response_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && response_ch.valid && response_ch.ready) begin
			beats_out++;
			observed = response_ch.data;
			status_seen[observed.status]++;
			if (pending_results.size() == 0) begin
				$error("response beat with nothing pending: status %0d", observed.status);
				failures++;
			end else begin
				oldest = pending_results.pop_front();
				if (observed.status !== oldest.status) begin
					$error("status: expected %0d, got %0d", oldest.status, observed.status);
					failures++;
				end
				if (observed.command_length !== oldest.command_length) begin
					$error("command_length: expected %0d, got %0d",
						oldest.command_length, observed.command_length);
					failures++;
				end
				if (observed.read_data !== oldest.read_data) begin
					$error("read_data: expected 0x%02h, got 0x%02h",
						oldest.read_data, observed.read_data);
					failures++;
				end
				if (observed.in_quotes !== oldest.in_quotes) begin
					$error("in_quotes: expected %0d, got %0d",
						oldest.in_quotes, observed.in_quotes);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((request_ch.valid && request_ch.ready)
					|| (response_ch.valid && response_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no beat moved for %0d cycles", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int cur_phase;
		int roll;
		arst_n = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.data = '0;
		response_ch.ready = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		fill_len = '0;
		held_len = '0;
		first_pos = '0;
		quote_open = 1'b0;
		busy_held = 1'b0;
		first_seen = 1'b0;
		first_printable = 1'b0;
		cur_phase = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

		while (beats_in - DIR_ROWS < RANDOM_ITEMS) begin
			phase = (beats_in - DIR_ROWS) * 4 / RANDOM_ITEMS;
			if (phase != cur_phase) begin
				cur_phase = phase;
				case (phase)
				1: begin
					src_idle_pct = 52;
					sink_stall_pct = 0;
				end
				2: begin
					@(negedge clk);
					request_ch.valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
					src_idle_pct = 0;
					sink_stall_pct = 52;
					hold_req++;
				end
				default: begin
					src_idle_pct = 31;
					sink_stall_pct = 31;
					send_byte(8'h41);
					repeat (514)
						send_byte(BYTE_W'($urandom_range(8'h23, CH_PRINT_HI)));
					finish_line(12);
				end
				endcase
			end
			roll = $urandom_range(99);
			if (roll < 70) begin
				feed_line(($urandom_range(9) == 0) ? $urandom_range(11, 40)
					: $urandom_range(1, 10), 1'b1);
				finish_line($urandom_range(1, 4));
			end else if (roll < 85) begin
				repeat ($urandom_range(1, 6))
					send_item(item_t'{KIND_W'($urandom_range(3)),
						BYTE_W'($urandom_range(255)), pick_index()});
			end else begin
				feed_line($urandom_range(0, 8), 1'b0);
				finish_line($urandom_range(1, 3));
			end
		end

		@(negedge clk);
		request_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Run moved %0d request and %0d response beats through four idle/stall mixes.",
			beats_in, beats_out);
		$display("Lines held %0d, blank %0d; overflow drops %0d, busy rejects %0d, reads %0d.",
			status_seen[ST_READY], status_seen[ST_BLANK], status_seen[ST_OVERFLOW],
			status_seen[ST_BUSY], status_seen[ST_READ]);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
hdl/atcl_pkg.sv
hdl/atcl_stream_if.sv
hdl/atcl_ram.sv
hdl/at_command_line_assembler.sv
test/at_command_line_assembler_test.sv
